// ----- src/gdcm_pkg.sv -----
package gdcm_pkg;

    // Event codes
    localparam logic [3:0] FN_LEFT_Y  = 4'd0;
    localparam logic [3:0] FN_RIGHT_X = 4'd1;
    localparam logic [3:0] FN_RIGHT_Y = 4'd2;
    localparam logic [3:0] FN_TRIG_L  = 4'd3;
    localparam logic [3:0] FN_TRIG_R  = 4'd4;
    localparam logic [3:0] FN_BUMP_L  = 4'd5;
    localparam logic [3:0] FN_BUMP_R  = 4'd6;
    localparam logic [3:0] FN_UP      = 4'd7;
    localparam logic [3:0] FN_DOWN    = 4'd8;
    localparam logic [3:0] FN_LEFT    = 4'd9;
    localparam logic [3:0] FN_RIGHT   = 4'd10;
    localparam logic [3:0] FN_TICK    = 4'd11;

    // Configuration register indexes
    localparam logic [1:0] CFG_DEAD_ZONE  = 2'd0;
    localparam logic [1:0] CFG_DRIVE_SCL  = 2'd1;
    localparam logic [1:0] CFG_GIMBAL_SCL = 2'd2;
    localparam logic [1:0] CFG_TRIG_THR   = 2'd3;

    // Configuration reset values
    localparam logic [14:0] RST_DEAD_ZONE  = 15'd3277;
    localparam logic [6:0]  RST_DRIVE_SCL  = 7'd90;
    localparam logic [6:0]  RST_GIMBAL_SCL = 7'd5;
    localparam logic [14:0] RST_TRIG_THR   = 15'd16384;

    // Fixed-point one and frame constants
    localparam logic [15:0] Q_ONE      = 16'h8000;
    localparam logic [7:0]  FRAME_HEAD = 8'h81;

    // Divide by 5 as multiply by 205 / 1024, exact for magnitudes up to 1023
    localparam logic [7:0] RECIP_5     = 8'd205;
    localparam int         RECIP_SHIFT = 10;

    // Modifier bit positions
    localparam int MOD_BRAKE = 0;
    localparam int MOD_FRONT = 1;
    localparam int MOD_REAR  = 2;

    // Quotient width of the response divide
    localparam int QW = 7;

    // Datapath commands from the controller
    typedef struct packed {
        logic       capture;
        logic       prep;
        logic       mul_d;
        logic       mul_den;
        logic       mul_s;
        logic       div_init;
        logic       div_step;
        logic [2:0] div_bit;
        logic       apply;
        logic       sum;
        logic       check;
        logic       send;
        logic [2:0] byte_idx;
    } t_cmd;

    // Datapath status to the controller
    typedef struct packed {
        logic [3:0] in_func;
        logic       out_free;
    } t_stat;

endpackage

// ----- src/gamepad_drive_command_mapper.sv -----
// Stick events: busy from the accept on (prep, three multiplies, divide setup,
//   7 restoring divide steps, update); a new item is accepted only after the update.
// Other non-tick events: the update step, then back to idle. Tick: sum, then check, then one
//   frame byte per cycle into the output register while it is free; the next item waits for the last byte.
// The stick path runs the multiply sequence shared by all stick events, then the one-bit-per-cycle divide.
// Synchronous active-low reset restores default configuration and clears all command state.
module gamepad_drive_command_mapper (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] axis_value, [16] pressed, [23:17] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] func
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    output logic        m_axis_tlast,   // last_byte
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import gdcm_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    gdcm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    gdcm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_func       (s_axis_tuser),
        .i_axis_value (s_axis_tdata[15:0]),
        .i_pressed    (s_axis_tdata[16]),
        .i_cfg_we     (i_cfg_valid & o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_frame_byte (m_axis_tdata),
        .o_last_byte  (m_axis_tlast)
    );

endmodule

// ----- src/gdcm_ctrl.sv -----
module gdcm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  gdcm_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output gdcm_pkg::t_cmd  o_cmd
);
    import gdcm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_PREP     = 11'b000_0000_0010,
        S_MUL_D    = 11'b000_0000_0100,
        S_MUL_DEN  = 11'b000_0000_1000,
        S_MUL_S    = 11'b000_0001_0000,
        S_DIV_INIT = 11'b000_0010_0000,
        S_DIV      = 11'b000_0100_0000,
        S_APPLY    = 11'b000_1000_0000,
        S_SUM      = 11'b001_0000_0000,
        S_CHECK    = 11'b010_0000_0000,
        S_SEND     = 11'b100_0000_0000
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic       accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready & i_in_valid;

    // Next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.in_func inside {FN_LEFT_Y, FN_RIGHT_X, FN_RIGHT_Y}) begin
                        n_state = S_PREP;
                    end else if (i_stat.in_func == FN_TICK) begin
                        n_state = S_SUM;
                    end else begin
                        n_state = S_APPLY;
                    end
                end
            end
            S_PREP:     n_state = S_MUL_D;
            S_MUL_D:    n_state = S_MUL_DEN;
            S_MUL_DEN:  n_state = S_MUL_S;
            S_MUL_S:    n_state = S_DIV_INIT;
            S_DIV_INIT: begin
                n_state = S_DIV;
                n_cnt   = 3'(QW - 1);
            end
            S_DIV: begin
                if (r_cnt == 3'd0) begin
                    n_state = S_APPLY;
                end else begin
                    n_cnt = r_cnt - 3'd1;
                end
            end
            S_APPLY:    n_state = S_IDLE;
            S_SUM:      n_state = S_CHECK;
            S_CHECK: begin
                n_state = S_SEND;
                n_cnt   = 3'd0;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    if (r_cnt == 3'd7) begin
                        n_state = S_IDLE;
                    end else begin
                        n_cnt = r_cnt + 3'd1;
                    end
                end
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Command decode
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept;
        o_cmd.prep     = (r_state == S_PREP);
        o_cmd.mul_d    = (r_state == S_MUL_D);
        o_cmd.mul_den  = (r_state == S_MUL_DEN);
        o_cmd.mul_s    = (r_state == S_MUL_S);
        o_cmd.div_init = (r_state == S_DIV_INIT);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.div_bit  = r_cnt;
        o_cmd.apply    = (r_state == S_APPLY);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.send     = (r_state == S_SEND) & i_stat.out_free;
        o_cmd.byte_idx = r_cnt;
    end

endmodule

// ----- src/gdcm_dp.sv -----
module gdcm_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gdcm_pkg::t_cmd  i_cmd,
    output gdcm_pkg::t_stat o_stat,
    // input item
    input  logic [3:0]     i_func,
    input  logic [15:0]    i_axis_value,
    input  logic           i_pressed,
    // configuration write
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [14:0]    i_cfg_data,
    // result item
    input  logic           i_out_ready,
    output logic           o_out_valid,
    output logic [7:0]     o_frame_byte,
    output logic           o_last_byte
);
    import gdcm_pkg::*;

    // Configuration
    logic [14:0] r_dead_zone, r_trig_thr;
    logic [6:0]  r_drive_scl, r_gimbal_scl;

    // Command state
    logic              r_camera;
    logic [2:0]        r_mods;
    logic signed [7:0] r_left, r_right, r_tilt, r_pan;

    // Captured item
    logic [3:0]         r_func;
    logic signed [15:0] r_val;
    logic               r_pressed;

    // Response curve
    logic [15:0]  r_d, r_den;
    logic         r_neg, r_zero;
    logic [6:0]   r_scale;
    logic [30:0]  r_sq, r_den2;
    logic [37:0]  r_num;
    logic [38:0]  r_rem;
    logic [QW-1:0] r_q;

    // Check byte
    logic signed [10:0] r_sum;
    logic [7:0]         r_check;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_data;
    logic       r_out_last;

    logic [16:0]        val_ext, mag17;
    logic [15:0]        mag;
    logic [38:0]        trial;
    logic [7:0]         resp;
    logic               over;
    logic [10:0]        sum_abs;
    logic [17:0]        div5_prod;
    logic [7:0]         div5_q;
    logic [7:0]         byte_sel;

    assign o_stat.in_func  = i_func;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone  <= RST_DEAD_ZONE;
            r_drive_scl  <= RST_DRIVE_SCL;
            r_gimbal_scl <= RST_GIMBAL_SCL;
            r_trig_thr   <= RST_TRIG_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEAD_ZONE:  r_dead_zone  <= i_cfg_data;
                CFG_DRIVE_SCL:  r_drive_scl  <= i_cfg_data[6:0];
                CFG_GIMBAL_SCL: r_gimbal_scl <= i_cfg_data[6:0];
                CFG_TRIG_THR:   r_trig_thr   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Magnitude of the captured value; deadzone offset and span follow in the prep step
    assign val_ext = {r_val[15], r_val};
    assign mag17   = r_val[15] ? (17'd0 - val_ext) : val_ext;
    assign mag     = mag17[15:0];

    // Division trial: divisor 2*den^2 shifted to the current quotient bit
    assign trial = 39'({r_den2, 1'b0}) << i_cmd.div_bit;

    // Signed shaped value; positive stick deflection maps negative
    assign resp = r_zero ? 8'd0
                : (r_neg ? (8'd0 - {1'b0, r_q}) : {1'b0, r_q});

    assign over = r_val > $signed({1'b0, r_trig_thr});

    // Check byte: truncating divide by 5 of the signed sum
    assign sum_abs   = r_sum[10] ? (11'd0 - r_sum) : r_sum;
    assign div5_prod = 18'(sum_abs[9:0]) * 18'(RECIP_5);
    assign div5_q    = 8'(div5_prod >> RECIP_SHIFT);

    // Frame byte select
    always_comb begin
        case (i_cmd.byte_idx)
            3'd0:    byte_sel = FRAME_HEAD;
            3'd1:    byte_sel = 8'd0;
            3'd2:    byte_sel = {5'd0, r_mods};
            3'd3:    byte_sel = r_left;
            3'd4:    byte_sel = r_right;
            3'd5:    byte_sel = r_tilt;
            3'd6:    byte_sel = r_pan;
            default: byte_sel = r_check;
        endcase
    end

    // Item capture, response curve pipeline and check byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_val     <= i_axis_value;
            r_pressed <= i_pressed;
        end
        if (i_cmd.prep) begin
            r_zero  <= mag <= {1'b0, r_dead_zone};
            r_d     <= mag - {1'b0, r_dead_zone};
            r_den   <= Q_ONE - {1'b0, r_dead_zone};
            r_neg   <= !r_val[15];
            r_scale <= (r_func == FN_LEFT_Y || (r_func == FN_RIGHT_Y && !r_camera))
                       ? r_drive_scl : r_gimbal_scl;
        end
        if (i_cmd.mul_d) begin
            r_sq <= 31'(32'(r_d) * 32'(r_d));
        end
        if (i_cmd.mul_den) begin
            r_den2 <= 31'(32'(r_den) * 32'(r_den));
        end
        if (i_cmd.mul_s) begin
            r_num <= 38'(r_sq) * 38'(r_scale);
        end
        // rounded quotient: (2*num + den^2) / (2*den^2)
        if (i_cmd.div_init) begin
            r_rem <= {r_num, 1'b0} + 39'(r_den2);
            r_q   <= '0;
        end
        if (i_cmd.div_step && r_rem >= trial) begin
            r_rem <= r_rem - trial;
            r_q   <= r_q | (QW'(1) << i_cmd.div_bit);
        end
        if (i_cmd.sum) begin
            r_sum <= $signed({8'd0, r_mods}) + 11'(r_left) + 11'(r_right)
                   + 11'(r_tilt) + 11'(r_pan);
        end
        if (i_cmd.check) begin
            r_check <= r_sum[10] ? (8'd0 - div5_q) : div5_q;
        end
    end

    // Command state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera <= 1'b0;
            r_mods   <= 3'd0;
            r_left   <= '0;
            r_right  <= '0;
            r_tilt   <= '0;
            r_pan    <= '0;
        end else if (i_cmd.apply) begin
            case (r_func)
                FN_LEFT_Y: begin
                    if (!r_camera) r_left <= resp;
                end
                FN_RIGHT_X: begin
                    if (r_camera) r_pan <= resp;
                end
                FN_RIGHT_Y: begin
                    if (r_camera) r_tilt <= resp;
                    else          r_right <= resp;
                end
                FN_TRIG_L: r_mods[MOD_REAR]  <= over;
                FN_TRIG_R: r_mods[MOD_FRONT] <= over;
                FN_BUMP_L: begin
                    r_camera <= r_pressed;
                    if (r_pressed) begin
                        r_left  <= '0;
                        r_right <= '0;
                    end else begin
                        r_tilt <= '0;
                        r_pan  <= '0;
                    end
                end
                FN_BUMP_R: begin
                    if (r_pressed) r_mods[MOD_BRAKE] <= !r_mods[MOD_BRAKE];
                end
                FN_UP:    r_tilt <= r_pressed ? 8'sd1 : 8'sd0;
                FN_DOWN:  r_tilt <= r_pressed ? -8'sd1 : 8'sd0;
                FN_LEFT:  r_pan  <= r_pressed ? 8'sd1 : 8'sd0;
                FN_RIGHT: r_pan  <= r_pressed ? -8'sd1 : 8'sd0;
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.send) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.send) begin
            r_out_data <= byte_sel;
            r_out_last <= (i_cmd.byte_idx == 3'd7);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_byte = r_out_data;
    assign o_last_byte  = r_out_last;

endmodule

// ----- sim/gdcm_frame_checker.sv -----
`timescale 1ns / 1ps

// Watches all three channels of the command mapper, keeps its own copy of the
// command state and register settings, and compares every frame byte that
// leaves the block with the byte expected next.
module gdcm_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [15:0] axis_value, [16] pressed, [23:17] zero
    input  logic [3:0]  s_axis_tuser,   // [3:0] func
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] frame_byte
    input  logic        m_axis_tlast,   // last_byte
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_bytes_checked
);

    import gdcm_pkg::*;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_byte_t;

    // Register settings as last written
    logic [14:0] dead_zone_q;
    logic [6:0]  drive_scale_q;
    logic [6:0]  gimbal_scale_q;
    logic [14:0] trig_thr_q;

    // Command state
    logic              camera_on;
    logic [2:0]        mods;
    logic signed [7:0] left_cmd;
    logic signed [7:0] right_cmd;
    logic signed [7:0] tilt_cmd;
    logic signed [7:0] pan_cmd;

    frame_byte_t pending_frame_bytes[$];

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_bytes_checked = 0;
    end

    // Deadzone, then quadratic response rounded half up, sign flipped
    function automatic logic signed [7:0] shaped_axis(input logic signed [15:0] pos,
                                                      input logic [6:0] scl);
        longint mag, dz, d, den, num, den2, r;
        mag = pos;
        if (mag < 0)
            mag = -mag;
        dz = dead_zone_q;
        if (mag <= dz)
            return 8'sd0;
        d    = mag - dz;
        den  = Q_ONE;
        den  = den - dz;
        num  = d * d * longint'(scl);
        den2 = den * den;
        r    = (2 * num + den2) / (2 * den2);
        return (pos > 0) ? 8'(-r) : 8'(r);
    endfunction

    task automatic queue_byte(input logic [7:0] value, input logic last);
        frame_byte_t b;
        b.frame_byte = value;
        b.last_byte  = last;
        pending_frame_bytes.push_back(b);
    endtask

    task automatic restore_defaults();
        dead_zone_q    = RST_DEAD_ZONE;
        drive_scale_q  = RST_DRIVE_SCL;
        gimbal_scale_q = RST_GIMBAL_SCL;
        trig_thr_q     = RST_TRIG_THR;
        camera_on      = 1'b0;
        mods           = '0;
        left_cmd       = '0;
        right_cmd      = '0;
        tilt_cmd       = '0;
        pan_cmd        = '0;
        pending_frame_bytes.delete();
    endtask

    task automatic write_setting(input logic [1:0] index, input logic [14:0] value);
        case (index)
            CFG_DEAD_ZONE:  dead_zone_q    = value;
            CFG_DRIVE_SCL:  drive_scale_q  = value[6:0];
            CFG_GIMBAL_SCL: gimbal_scale_q = value[6:0];
            CFG_TRIG_THR:   trig_thr_q     = value;
            default: ;
        endcase
    endtask

    // Update the command state for one event; a tick queues the whole frame
    task automatic apply_event(input logic [3:0] fn, input logic [15:0] raw,
                               input logic pressed);
        logic signed [15:0] pos;
        int                 level;
        int                 thr;
        int                 sum;
        int                 chk;
        logic               over;
        pos   = raw;
        level = pos;
        thr   = trig_thr_q;
        over  = level > thr;
        case (fn)
            FN_LEFT_Y: begin
                if (!camera_on)
                    left_cmd = shaped_axis(pos, drive_scale_q);
            end
            FN_RIGHT_X: begin
                if (camera_on)
                    pan_cmd = shaped_axis(pos, gimbal_scale_q);
            end
            FN_RIGHT_Y: begin
                if (camera_on)
                    tilt_cmd = shaped_axis(pos, gimbal_scale_q);
                else
                    right_cmd = shaped_axis(pos, drive_scale_q);
            end
            FN_TRIG_L: mods[MOD_REAR]  = over;
            FN_TRIG_R: mods[MOD_FRONT] = over;
            FN_BUMP_L: begin
                camera_on = pressed;
                if (pressed) begin
                    left_cmd  = '0;
                    right_cmd = '0;
                end else begin
                    pan_cmd  = '0;
                    tilt_cmd = '0;
                end
            end
            FN_BUMP_R: begin
                if (pressed)
                    mods[MOD_BRAKE] = ~mods[MOD_BRAKE];
            end
            FN_UP:    tilt_cmd = pressed ? 8'sd1 : 8'sd0;
            FN_DOWN:  tilt_cmd = pressed ? -8'sd1 : 8'sd0;
            FN_LEFT:  pan_cmd  = pressed ? 8'sd1 : 8'sd0;
            FN_RIGHT: pan_cmd  = pressed ? -8'sd1 : 8'sd0;
            FN_TICK: begin
                sum = mods;
                sum = sum + left_cmd + right_cmd + tilt_cmd + pan_cmd;
                chk = sum / 5;
                queue_byte(FRAME_HEAD, 1'b0);
                queue_byte(8'h00, 1'b0);
                queue_byte({5'b0, mods}, 1'b0);
                queue_byte(left_cmd, 1'b0);
                queue_byte(right_cmd, 1'b0);
                queue_byte(tilt_cmd, 1'b0);
                queue_byte(pan_cmd, 1'b0);
                queue_byte(chk[7:0], 1'b1);
            end
            default: ;
        endcase
    endtask

    task automatic compare_byte();
        frame_byte_t want;
        if (pending_frame_bytes.size() == 0) begin
            $error("frame byte %02h with none expected", m_axis_tdata);
            o_fail_count++;
        end else begin
            want = pending_frame_bytes.pop_front();
            if (want.frame_byte !== m_axis_tdata) begin
                $error("frame_byte: expected %02h, got %02h", want.frame_byte, m_axis_tdata);
                o_fail_count++;
            end
            if (want.last_byte !== m_axis_tlast) begin
                $error("last_byte: expected %0b, got %0b", want.last_byte, m_axis_tlast);
                o_fail_count++;
            end
            o_bytes_checked++;
        end
    endtask

    // Output first, then register writes, then the incoming item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                compare_byte();
            if (i_cfg_valid && o_cfg_ready)
                write_setting(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                apply_event(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[16]);
        end
        o_pending = pending_frame_bytes.size();
    end

endmodule

// ----- sim/gamepad_drive_command_mapper_test.sv -----
`timescale 1ns / 1ps

module gamepad_drive_command_mapper_test;

    import gdcm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 20;    // covers a trailing stick update
    localparam int HOLD_CYCLES  = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [3:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [14:0] i_cfg_data = '0;

    int fail_count;
    int pending;
    int bytes_checked;
    int events_sent = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int cur_dz  = RST_DEAD_ZONE;
    int cur_thr = RST_TRIG_THR;
    logic rx_hold_go = 1'b0;
    logic rx_hold = 1'b0;

    gamepad_drive_command_mapper u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    gdcm_frame_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_bytes_checked (bytes_checked)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Frame receiver: random stalls, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            m_axis_tready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (rx_hold_go);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $error("run limit of %0d cycles reached, %0d bytes still due", CYCLE_LIMIT, pending);
        $display("gamepad_drive_command_mapper_test failed");
        $finish;
    end

    // One event item; valid stays high between back-to-back items
    task automatic send_event(input logic [3:0] fn, input logic [15:0] level,
                              input logic pressed);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= {7'b0, pressed, level};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        events_sent++;
    endtask

    task automatic write_cfg(input logic [1:0] index, input logic [14:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain all frames and let a trailing stick update finish
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    function automatic logic [15:0] stick_level();
        case ($urandom_range(9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'(cur_dz);
            3: return 16'(-cur_dz);
            4: return 16'(cur_dz + 1);
            5: return 16'(-(cur_dz + 1));
            6: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] trigger_level();
        case ($urandom_range(5))
            0: return 16'(cur_thr);
            1: return 16'(cur_thr + 1);
            2: return 16'(cur_thr - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    // Random mix: sticks and buttons most often, then ticks, some triggers and unused codes
    task automatic run_random(input int count);
        int         sel;
        logic [3:0] fn;
        logic [15:0] level;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 22)
                fn = FN_TICK;
            else if (sel < 52)
                fn = FN_LEFT_Y + 4'($urandom_range(2));
            else if (sel < 62)
                fn = $urandom_range(1) ? FN_TRIG_L : FN_TRIG_R;
            else if (sel < 92)
                fn = FN_BUMP_L + 4'($urandom_range(5));
            else
                fn = FN_TICK + 4'($urandom_range(1, 4));
            level = (fn == FN_TRIG_L || fn == FN_TRIG_R) ? trigger_level() : stick_level();
            send_event(fn, level, 1'($urandom_range(1)));
        end
    endtask

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Default settings, sender idles lightly, receiver heavily
        tx_idle_pct = 14;
        rx_idle_pct = 49;
        send_event(FN_TICK,    16'h0000, 1'b0);   // all commands zero out of reset
        send_event(FN_LEFT_Y,  16'h7FFF, 1'b0);   // full forward, negated
        send_event(FN_RIGHT_Y, 16'h8000, 1'b0);   // full back
        send_event(FN_TRIG_L,  16'd16385, 1'b0);  // just over threshold
        send_event(FN_TRIG_R,  16'h7FFF, 1'b0);
        send_event(FN_BUMP_R,  16'h0000, 1'b1);   // brake on
        send_event(FN_BUMP_R,  16'hFFFF, 1'b0);   // release does nothing
        send_event(FN_TICK,    16'h0000, 1'b0);
        send_event(FN_LEFT_Y,  16'd3277, 1'b0);   // exactly at deadzone
        send_event(FN_RIGHT_Y, 16'hF332, 1'b0);   // one past negative deadzone
        send_event(FN_TRIG_R,  16'd16384, 1'b0);  // equal to threshold clears
        send_event(FN_TRIG_L,  16'h8000, 1'b0);
        send_event(FN_BUMP_R,  16'h0000, 1'b1);   // brake off
        send_event(FN_BUMP_L,  16'h0000, 1'b1);   // camera mode, drives zeroed
        send_event(FN_RIGHT_X, 16'h8000, 1'b0);
        send_event(FN_RIGHT_Y, 16'h7FFF, 1'b0);   // gimbal tilt in camera mode
        send_event(FN_LEFT_Y,  16'h7FFF, 1'b0);   // ignored in camera mode
        send_event(FN_TICK,    16'h0000, 1'b0);
        send_event(FN_UP,      16'h0000, 1'b1);
        send_event(FN_LEFT,    16'h0000, 1'b1);
        send_event(FN_TICK,    16'h0000, 1'b0);
        send_event(FN_DOWN,    16'h0000, 1'b1);
        send_event(FN_RIGHT,   16'h0000, 1'b1);
        send_event(FN_BUMP_L,  16'h0000, 1'b0);   // drive mode, gimbal zeroed
        send_event(FN_RIGHT_X, 16'd20000, 1'b0);  // ignored outside camera mode
        send_event(4'hF,       16'hFFFF, 1'b1);   // unused code
        send_event(FN_TICK,    16'h0000, 1'b0);
        run_random(46);
        settle();

        // No deadzone, full scales, zero threshold; idling swapped
        write_cfg(CFG_DEAD_ZONE,  15'd0);
        write_cfg(CFG_DRIVE_SCL,  15'd127);
        write_cfg(CFG_GIMBAL_SCL, 15'd127);
        write_cfg(CFG_TRIG_THR,   15'd0);
        cur_dz  = 0;
        cur_thr = 0;
        tx_idle_pct = 49;
        rx_idle_pct = 14;
        run_random(46);
        settle();

        // Widest deadzone, tiny or zero scales, top threshold; no idling
        write_cfg(CFG_DEAD_ZONE,  15'h7FFF);
        write_cfg(CFG_DRIVE_SCL,  15'd1);
        write_cfg(CFG_GIMBAL_SCL, 15'd0);
        write_cfg(CFG_TRIG_THR,   15'h7FFF);
        cur_dz  = 32767;
        cur_thr = 32767;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_go = 1'b1;
        for (int k = 0; k < 10; k++)
            send_event(FN_TICK, 16'h0000, 1'b0);
        run_random(36);
        settle();

        // Random mid-range settings, scale writes carry junk upper bits
        cur_dz  = $urandom_range(12000);
        cur_thr = $urandom_range(32767);
        write_cfg(CFG_DEAD_ZONE,  15'(cur_dz));
        write_cfg(CFG_DRIVE_SCL,  15'($urandom));
        write_cfg(CFG_GIMBAL_SCL, 15'($urandom));
        write_cfg(CFG_TRIG_THR,   15'(cur_thr));
        run_random(46);
        settle();

        $display("Sent %0d controller events under default, both extreme and random settings;",
                 events_sent);
        $display("compared %0d frame bytes, including a long output stall.", bytes_checked);
        if (fail_count == 0 && pending == 0)
            $display("gamepad_drive_command_mapper_test passed");
        else
            $display("gamepad_drive_command_mapper_test failed");
        $finish;
    end

endmodule
